[rtl/core/cht_pkg.sv]
`timescale 1ns / 1ps

package cht_pkg;

  localparam int unsigned DefBuckets = 53;
  localparam int unsigned DefEntries = 256;
  localparam int unsigned DefKeyBits = 32;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned InKeyW  = 32;

  typedef enum logic [FuncW-1:0] {
    FnFind   = 3'd0,
    FnInsert = 3'd1,
    FnErase  = 3'd2,
    FnChange = 3'd3,
    FnClear  = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 3'd0,
    StUpdated = 3'd1,
    StMissing = 3'd2,
    StExists  = 3'd3,
    StNoSpace = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    SIdle,
    SBucket,
    SHeadRd,
    SHeadWait,
    SWalk,
    SWalkWait,
    SDecide,
    SUnlinkRd,
    SUnlinkWait,
    SUnlinkP,
    SUnlinkN,
    SUnlinkSelf,
    SLinkRd,
    SLinkWait,
    SLinkWr,
    SFreeRd,
    SFreeWait,
    SClear,
    SDone
  } state_e;

endpackage

[rtl/core/cht_mod.sv]
`timescale 1ns / 1ps

module cht_mod
  import cht_pkg::*;
#(
  parameter int unsigned Buckets = DefBuckets,
  parameter int unsigned KeyBits = DefKeyBits,
  localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [KeyBits-1:0] key_i,
  output logic               done_o,
  output logic [BW-1:0]      bucket_o
);

  // The key is reduced 16 bits at a time from the top, each step being a
  // registered reciprocal multiply followed by a multiply-back and subtract.
  localparam int unsigned ChunkW = 16;
  localparam int unsigned NChunk = (KeyBits + ChunkW - 1) / ChunkW;
  localparam int unsigned PadW   = NChunk * ChunkW;
  localparam int unsigned TW     = BW + ChunkW;
  localparam int unsigned RW     = TW + 1;
  localparam int unsigned SH     = TW + BW;
  localparam int unsigned PW     = TW + RW;
  localparam int unsigned QW     = TW + 1 - BW;
  localparam int unsigned CNW    = $clog2(NChunk + 1);
  localparam logic [RW-1:0] Recip =
      RW'(((64'd1 << SH) + 64'(Buckets) - 64'd1) / 64'(Buckets));

  logic [PadW-1:0] rem_q;
  logic [BW-1:0]   acc_q;
  logic [TW-1:0]   t_q;
  logic [QW-1:0]   q_q;
  logic            busy_q;
  logic            ph_q;
  logic [CNW-1:0]  cnt_q;
  logic [TW-1:0]   tval;
  logic [PW-1:0]   prod;
  logic [TW-1:0]   qb;
  logic [TW-1:0]   diff;

  assign tval = {acc_q, rem_q[PadW-1 -: ChunkW]};
  assign prod = PW'(tval) * PW'(Recip);
  assign qb   = TW'(q_q) * TW'(Buckets);
  assign diff = t_q - qb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (!ph_q) begin
        ph_q <= 1'b1;
      end else begin
        ph_q  <= 1'b0;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNW'(NChunk - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= PadW'(key_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (!ph_q) begin
        t_q   <= tval;
        q_q   <= prod[SH +: QW];
        rem_q <= rem_q << ChunkW;
      end else begin
        acc_q <= diff[BW-1:0];
      end
    end
  end

  assign done_o   = !busy_q && !start_i;
  assign bucket_o = acc_q;

endmodule

[rtl/core/chained_hash_table_unit.sv]
`timescale 1ns / 1ps

// Key/value table with separate chaining over a fixed entry pool.
// Slave beats carry an operation in s_axis_tdata; each produces exactly one
// master beat with status, found flag, value and entry count.
// The bucket is found by reducing the key 16 bits at a time, then the head
// is read and the chain is walked one slot at a time. Inserting a new key and
// erase go on to take a slot from or return it to the free stack and link or
// unlink it. Change key walks two chains, unlinks and relinks the slot.
// The next slave beat is accepted only once the result beat has been taken,
// so one item is in flight at a time.
// Reset, and the clear operation, sweep the bucket heads and the free stack
// one entry a cycle (over the larger of BUCKETS and ENTRIES); no item is taken
// during the sweep and reset produces no beat.
// The result sits in an output register; while the receiver stalls the
// block holds it and accepts no new item.
module chained_hash_table_unit
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS  = DefBuckets,
  parameter int unsigned ENTRIES  = DefEntries,
  parameter int unsigned KEY_BITS = DefKeyBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[2:0], key[34:3], value[66:35], new_key[98:67], zero fill
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], found[3], result_value[35:4], entry_count[44:36], zero fill
  output logic [47:0]  m_axis_tdata
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW = $clog2(ENTRIES);
  localparam int unsigned LW = SW + 1;
  localparam logic [LW-1:0] Nil = LW'(ENTRIES);
  localparam int unsigned CKW = (KEY_BITS < InKeyW) ? KEY_BITS : InKeyW;
  localparam int unsigned ClrLen = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
  localparam int unsigned CW = $clog2(ClrLen + 1);

  logic [LW-1:0]       head_mem [BUCKETS];
  logic [KEY_BITS-1:0] key_mem  [ENTRIES];
  logic [ValueW-1:0]   val_mem  [ENTRIES];
  logic [LW-1:0]       next_mem [ENTRIES];
  logic [LW-1:0]       prev_mem [ENTRIES];
  logic [SW-1:0]       free_mem [ENTRIES];

  state_e state_q, state_d;
  logic [FuncW-1:0]    func_q;
  logic [KEY_BITS-1:0] key_q, nkey_q, cur_key_q, cur_key_d;
  logic [ValueW-1:0]   val_q;
  logic                phase_q, phase_d;
  logic [BW-1:0]       bkt_q, bkt_d;
  logic [LW-1:0]       slot_q, slot_d;
  logic [LW-1:0]       steps_q, steps_d;
  logic [LW-1:0]       cnt_q, cnt_d;
  logic [LW-1:0]       fs_q, fs_d;
  logic [CW-1:0]       clr_q, clr_d;
  logic                boot_q, boot_d;
  logic [LW-1:0]       pn_q, pn_d, pp_q, pp_d;
  logic [StatusW-1:0]  st_q, st_d;
  logic                fnd_q, fnd_d;
  logic [ValueW-1:0]   rv_q, rv_d;
  logic                ov_q, ov_d;

  logic [LW-1:0]       head_rd_q;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [ValueW-1:0]   val_rd_q;
  logic [LW-1:0]       next_rd_q, prev_rd_q;
  logic [SW-1:0]       free_rd_q;

  logic          hd_we;  logic [BW-1:0] hd_wa; logic [LW-1:0] hd_wd; logic [BW-1:0] hd_ra;
  logic          k_we;   logic [SW-1:0] s_wa;  logic [SW-1:0] s_ra;
  logic          v_we;   logic [KEY_BITS-1:0] k_wd; logic [ValueW-1:0] v_wd;
  logic          n_we;   logic [SW-1:0] n_wa;  logic [LW-1:0] n_wd;
  logic          p_we;   logic [SW-1:0] p_wa;  logic [LW-1:0] p_wd;
  logic          f_we;   logic [SW-1:0] f_wa;  logic [SW-1:0] f_wd; logic [SW-1:0] f_ra;

  logic          md_start, md_done;
  logic [BW-1:0] md_bucket;
  logic          accept;

  cht_mod #(.Buckets(BUCKETS), .KeyBits(KEY_BITS)) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .key_i    (cur_key_d),
    .done_o   (md_done),
    .bucket_o (md_bucket)
  );

  always_ff @(posedge clk_i) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    head_rd_q <= head_mem[hd_ra];
    if (k_we) key_mem[s_wa] <= k_wd;
    if (v_we) val_mem[s_wa] <= v_wd;
    if (n_we) next_mem[n_wa] <= n_wd;
    if (p_we) prev_mem[p_wa] <= p_wd;
    if (f_we) free_mem[f_wa] <= f_wd;
    key_rd_q  <= key_mem[s_ra];
    val_rd_q  <= val_mem[s_ra];
    next_rd_q <= next_mem[s_ra];
    prev_rd_q <= prev_mem[s_ra];
    free_rd_q <= free_mem[f_ra];
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b0, 9'(cnt_q), rv_q, fnd_q, st_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      boot_q  <= 1'b1;
      cnt_q   <= '0;
      fs_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      boot_q  <= boot_d;
      cnt_q   <= cnt_d;
      fs_q    <= fs_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tdata[2:0];
      key_q  <= KEY_BITS'(s_axis_tdata[3 +: CKW]);
      val_q  <= s_axis_tdata[35 +: 32];
      nkey_q <= KEY_BITS'(s_axis_tdata[67 +: CKW]);
    end
    cur_key_q <= cur_key_d;
    phase_q   <= phase_d;
    bkt_q     <= bkt_d;
    slot_q    <= slot_d;
    steps_q   <= steps_d;
    pn_q      <= pn_d;
    pp_q      <= pp_d;
    st_q      <= st_d;
    fnd_q     <= fnd_d;
    rv_q      <= rv_d;
  end

  always_comb begin
    state_d = state_q; cur_key_d = cur_key_q; phase_d = phase_q; bkt_d = bkt_q;
    slot_d = slot_q; steps_d = steps_q; cnt_d = cnt_q; fs_d = fs_q; clr_d = clr_q;
    boot_d = boot_q;
    pn_d = pn_q; pp_d = pp_q; st_d = st_q; fnd_d = fnd_q; rv_d = rv_q; ov_d = ov_q;
    md_start = 1'b0;
    hd_we = 1'b0; hd_wa = bkt_q; hd_wd = Nil; hd_ra = bkt_q;
    k_we = 1'b0; v_we = 1'b0; s_wa = slot_q[SW-1:0]; s_ra = slot_q[SW-1:0];
    k_wd = cur_key_q; v_wd = val_q;
    n_we = 1'b0; n_wa = slot_q[SW-1:0]; n_wd = Nil;
    p_we = 1'b0; p_wa = slot_q[SW-1:0]; p_wd = Nil;
    f_we = 1'b0; f_wa = fs_q[SW-1:0]; f_wd = slot_q[SW-1:0]; f_ra = fs_q[SW-1:0];
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (accept) begin
          st_d = StOk; fnd_d = 1'b0; rv_d = '0;
          phase_d = 1'b0;
          cur_key_d = (s_axis_tdata[2:0] == FnChange) ? KEY_BITS'(s_axis_tdata[67 +: CKW])
                                                       : KEY_BITS'(s_axis_tdata[3 +: CKW]);
          case (s_axis_tdata[2:0])
            FnFind, FnInsert, FnErase, FnChange: begin
              md_start = 1'b1;
              state_d  = SBucket;
            end
            FnClear: begin
              clr_d = '0;
              state_d = SClear;
            end
            default: state_d = SDone;
          endcase
        end
      end
      SBucket: begin
        if (md_done) begin
          bkt_d = md_bucket;
          state_d = SHeadRd;
        end
      end
      SHeadRd: state_d = SHeadWait;
      SHeadWait: begin
        slot_d = head_rd_q;
        steps_d = '0;
        state_d = SWalk;
      end
      SWalk: begin
        if (slot_q >= Nil || steps_q >= Nil) begin
          slot_d = Nil;
          state_d = SDecide;
        end else begin
          state_d = SWalkWait;
        end
      end
      SWalkWait: begin
        if (key_rd_q == cur_key_q) begin
          state_d = SDecide;
        end else begin
          slot_d = next_rd_q;
          steps_d = steps_q + 1'b1;
          state_d = SWalk;
        end
      end
      SDecide: begin
        state_d = SDone;
        case (func_q)
          FnFind: begin
            if (slot_q < Nil) begin
              fnd_d = 1'b1; rv_d = val_rd_q;
            end else st_d = StMissing;
          end
          FnInsert: begin
            if (slot_q < Nil) begin
              v_we = 1'b1; st_d = StUpdated;
            end else if (cnt_q >= Nil) begin
              st_d = StNoSpace;
            end else begin
              state_d = SFreeRd;
            end
          end
          FnErase: begin
            if (slot_q < Nil && cnt_q != '0) begin
              fnd_d = 1'b1; rv_d = val_rd_q;
              state_d = SUnlinkRd;
            end else st_d = StMissing;
          end
          FnChange: begin
            if (!phase_q) begin
              if (slot_q < Nil) st_d = StExists;
              else begin
                phase_d = 1'b1;
                cur_key_d = key_q;
                md_start = 1'b1;
                state_d = SBucket;
              end
            end else if (slot_q < Nil) begin
              state_d = SUnlinkRd;
            end else st_d = StMissing;
          end
          default: ;
        endcase
      end
      SFreeRd: begin
        f_ra = cnt_q[SW-1:0];
        state_d = SFreeWait;
      end
      SFreeWait: begin
        slot_d = {1'b0, free_rd_q};
        k_we = 1'b1; v_we = 1'b1;
        s_wa = free_rd_q;
        cnt_d = cnt_q + 1'b1;
        state_d = SLinkRd;
      end
      SUnlinkRd: state_d = SUnlinkWait;
      SUnlinkWait: begin
        pp_d = prev_rd_q; pn_d = next_rd_q;
        state_d = SUnlinkP;
      end
      SUnlinkP: begin
        if (pp_q < Nil) begin
          n_we = 1'b1; n_wa = pp_q[SW-1:0]; n_wd = pn_q;
        end else begin
          hd_we = 1'b1; hd_wd = pn_q;
        end
        state_d = SUnlinkN;
      end
      SUnlinkN: begin
        if (pn_q < Nil) begin
          p_we = 1'b1; p_wa = pn_q[SW-1:0]; p_wd = pp_q;
        end
        state_d = SUnlinkSelf;
      end
      SUnlinkSelf: begin
        n_we = 1'b1; p_we = 1'b1;
        if (func_q == FnErase) begin
          cnt_d = cnt_q - 1'b1;
          f_we = 1'b1; f_wa = SW'(cnt_q - 1'b1);
          state_d = SDone;
        end else begin
          k_we = 1'b1; k_wd = nkey_q;
          cur_key_d = nkey_q;
          md_start = 1'b1;
          state_d = SLinkRd;
        end
      end
      SLinkRd: begin
        if (func_q == FnChange) begin
          if (md_done) begin
            bkt_d = md_bucket;
            hd_ra = md_bucket;
            state_d = SLinkWait;
          end
        end else begin
          state_d = SLinkWait;
        end
      end
      SLinkWait: begin
        pn_d = head_rd_q;
        n_we = 1'b1; n_wd = head_rd_q;
        p_we = 1'b1; p_wd = Nil;
        hd_we = 1'b1; hd_wd = slot_q;
        state_d = SLinkWr;
      end
      SLinkWr: begin
        if (pn_q < Nil) begin
          p_we = 1'b1; p_wa = pn_q[SW-1:0]; p_wd = slot_q;
        end
        state_d = SDone;
      end
      SClear: begin
        if (clr_q < CW'(BUCKETS)) begin
          hd_we = 1'b1; hd_wa = clr_q[BW-1:0]; hd_wd = Nil;
        end
        if (clr_q < CW'(ENTRIES)) begin
          f_we = 1'b1; f_wa = clr_q[SW-1:0]; f_wd = clr_q[SW-1:0];
        end
        cnt_d = '0; fs_d = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == CW'(ClrLen - 1)) begin
          boot_d = 1'b0;
          state_d = boot_q ? SIdle : SDone;
        end
      end
      SDone: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid);
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Nil);
  a_state_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(state_q));

endmodule
